// File: hdl/gmc_pkg.sv
package gmc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE_OPEN   = 3'd0,
    ST_IDLE_CLOSED = 3'd1,
    ST_OPENING     = 3'd2,
    ST_CLOSING     = 3'd3,
    ST_STOPPED     = 3'd4,
    ST_REVERSING   = 3'd5
  } gate_state_t;

  typedef struct packed {
    logic security_open;
    logic security_close;
    logic driver_open;
    logic driver_close;
    logic open_limit;
    logic closed_limit;
    logic obstacle;
  } sample_t;

  typedef struct packed {
    logic open_req;
    logic close_req;
    logic clash;
  } request_t;

  function automatic request_t decode_buttons(input sample_t s);
    request_t r;
    r.open_req  = (s.security_open && !s.security_close) ||
                  (s.driver_open && !s.driver_close && !s.security_close && !s.security_open);
    r.close_req = (s.security_close && !s.security_open) ||
                  (s.driver_close && !s.driver_open && !s.security_close && !s.security_open);
    r.clash     = (s.driver_open && s.driver_close) || (s.security_open && s.security_close);
    return r;
  endfunction

endpackage

// File: hdl/gmc_in_reg.sv
module gmc_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gmc_pkg::sample_t in_sample,
  input  logic             advance,
  output logic             smp_valid,
  output gmc_pkg::sample_t smp_sample
);

  logic             valid_r;
  logic             valid_nxt;
  logic             load;
  gmc_pkg::sample_t sample_r;

  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold the sample until it moves on
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= in_sample;
    end
  end

  assign smp_valid  = valid_r;
  assign smp_sample = sample_r;

endmodule

// File: hdl/gmc_core.sv
module gmc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             smp_valid,
  input  gmc_pkg::sample_t smp_sample,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_gate_state,
  output logic             out_manual_mode,
  output logic             out_green_led,
  output logic             out_red_led
);

  gmc_pkg::gate_state_t state_r;
  gmc_pkg::gate_state_t state_nxt;
  logic                 mode_r;
  logic                 mode_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 green_r;
  logic                 green_nxt;
  logic                 red_r;
  logic                 red_nxt;
  gmc_pkg::request_t    req;

  assign advance       = smp_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);
  assign req           = gmc_pkg::decode_buttons(smp_sample);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    if (smp_sample.obstacle) begin
      if (state_r == gmc_pkg::ST_CLOSING) begin
        state_nxt = gmc_pkg::ST_REVERSING;
        mode_nxt  = 1'b0;
      end
    end else begin
      unique case (state_r)
        gmc_pkg::ST_IDLE_OPEN: begin
          if (req.close_req) begin
            state_nxt = gmc_pkg::ST_CLOSING;
            mode_nxt  = 1'b0;
          end
        end
        gmc_pkg::ST_IDLE_CLOSED: begin
          if (req.open_req) begin
            state_nxt = gmc_pkg::ST_OPENING;
            mode_nxt  = 1'b0;
          end
        end
        gmc_pkg::ST_OPENING: begin
          priority if (smp_sample.open_limit) begin
            state_nxt = gmc_pkg::ST_IDLE_OPEN;
            mode_nxt  = 1'b0;
          end else if (req.clash) begin
            state_nxt = gmc_pkg::ST_STOPPED;
            mode_nxt  = 1'b0;
          end else if (smp_sample.security_close && !smp_sample.security_open) begin
            state_nxt = gmc_pkg::ST_CLOSING;
            mode_nxt  = 1'b0;
          end else if (!mode_r && req.open_req) begin
            mode_nxt  = 1'b1;
          end else if (mode_r && !req.open_req) begin
            state_nxt = gmc_pkg::ST_STOPPED;
            mode_nxt  = 1'b0;
          end else begin
            state_nxt = state_r;
          end
        end
        gmc_pkg::ST_CLOSING: begin
          priority if (smp_sample.closed_limit) begin
            state_nxt = gmc_pkg::ST_IDLE_CLOSED;
            mode_nxt  = 1'b0;
          end else if (req.clash) begin
            state_nxt = gmc_pkg::ST_STOPPED;
            mode_nxt  = 1'b0;
          end else if (smp_sample.security_open && !smp_sample.security_close) begin
            state_nxt = gmc_pkg::ST_OPENING;
            mode_nxt  = 1'b0;
          end else if (!mode_r && req.close_req) begin
            mode_nxt  = 1'b1;
          end else if (mode_r && !req.close_req) begin
            state_nxt = gmc_pkg::ST_STOPPED;
            mode_nxt  = 1'b0;
          end else begin
            state_nxt = state_r;
          end
        end
        gmc_pkg::ST_STOPPED: begin
          if (req.open_req) begin
            state_nxt = gmc_pkg::ST_OPENING;
            mode_nxt  = 1'b0;
          end else if (req.close_req) begin
            state_nxt = gmc_pkg::ST_CLOSING;
            mode_nxt  = 1'b0;
          end
        end
        gmc_pkg::ST_REVERSING: begin
          state_nxt = gmc_pkg::ST_STOPPED;
          mode_nxt  = 1'b0;
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_comb begin
    green_nxt = (state_nxt == gmc_pkg::ST_OPENING) || (state_nxt == gmc_pkg::ST_REVERSING);
    red_nxt   = (state_nxt == gmc_pkg::ST_CLOSING);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmc_pkg::ST_IDLE_CLOSED;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
        mode_r  <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gate_state  = state_r;
  assign out_manual_mode = mode_r;
  assign out_green_led   = green_r;
  assign out_red_led     = red_r;

`ifndef SYNTHESIS
  a_manual_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> (state_r == gmc_pkg::ST_OPENING || state_r == gmc_pkg::ST_CLOSING))
    else $error("manual mode outside motion");

  a_obstacle_reverses: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && smp_sample.obstacle && state_r == gmc_pkg::ST_CLOSING)
    |=> (state_r == gmc_pkg::ST_REVERSING && !mode_r))
    else $error("obstacle while closing did not reverse");

  a_leds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(green_r && red_r))
    else $error("both leds lit");

  a_red_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r == (state_r == gmc_pkg::ST_CLOSING)))
    else $error("red led disagrees with state");

  a_no_advance_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(state_r))
    else $error("state moved while result held");
`endif

endmodule

// File: hdl/gate_motion_controller_top.sv
// Gate motion controller.
// Input channel: one sample per transfer of the security and driver
// open/close buttons, the open and closed limit switches and the obstacle
// sensor (in_valid / in_stall). Result channel: one result per sample,
// giving the gate state after that sample, the manual mode bit and the
// green/red LEDs (out_valid / out_stall).
// A sample taken in is registered in the sample register, then stepped
// through the next-state logic into the state and result registers once
// the result register is free or being emptied; its result is then offered.
// Throughput: one sample per cycle while out_stall is low; the next-state
// logic between the sample register and the state register is combinational.
// A held result does not block intake: one further sample waits in the
// sample register and in_stall rises only once that is full too.
// Reset (rst_n low, synchronous): gate idle closed, auto mode, both
// stages empty.
module gate_motion_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_security_open,
  input  logic       in_security_close,
  input  logic       in_driver_open,
  input  logic       in_driver_close,
  input  logic       in_open_limit,
  input  logic       in_closed_limit,
  input  logic       in_obstacle,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_gate_state,
  output logic       out_manual_mode,
  output logic       out_green_led,
  output logic       out_red_led
);

  gmc_pkg::sample_t in_sample;
  gmc_pkg::sample_t smp_sample;
  logic             smp_valid;
  logic             advance;

  always_comb begin
    in_sample.security_open  = in_security_open;
    in_sample.security_close = in_security_close;
    in_sample.driver_open    = in_driver_open;
    in_sample.driver_close   = in_driver_close;
    in_sample.open_limit     = in_open_limit;
    in_sample.closed_limit   = in_closed_limit;
    in_sample.obstacle       = in_obstacle;
  end

  gmc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .advance    (advance),
    .smp_valid  (smp_valid),
    .smp_sample (smp_sample)
  );

  gmc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .smp_valid       (smp_valid),
    .smp_sample      (smp_sample),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gate_state  (out_gate_state),
    .out_manual_mode (out_manual_mode),
    .out_green_led   (out_green_led),
    .out_red_led     (out_red_led)
  );

endmodule
